>>> hdl/zrv_pkg.sv
// Shared types and constants for the zero-run visibility decoder.
// Holds the microcode word layout, action codes and sizing constants.
// No dependencies; compile first.
package zrv_pkg;

    // Sizing
    localparam int MAX_LEAVES = 4096;
    localparam int LEAF_W     = 13;
    localparam int ROW_W      = $clog2(MAX_LEAVES / 8 + 1);
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [7:0]        FILL_BYTE = 8'hff;
    localparam logic [LEAF_W:0]   ROUND_UP  = (LEAF_W + 1)'(7);

    // Register index
    localparam logic REG_LEAF_COUNT = 1'b0;

    // Input action codes
    localparam logic [1:0] ACT_CONT = 2'd0;
    localparam logic [1:0] ACT_NEW  = 2'd1;
    localparam logic [1:0] ACT_FILL = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Microprogram steps
    typedef logic [1:0] step_t;
    localparam step_t STEP_LOAD   = 2'd0;
    localparam step_t STEP_START  = 2'd1;
    localparam step_t STEP_SETRUN = 2'd2;
    localparam step_t STEP_PUSH   = 2'd3;
    localparam int    UC_DEPTH    = 4;

    // Datapath operation of a step
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_SETRUN = 2'd2,
        OP_PUSH   = 2'd3
    } op_t;

    // Jump condition of a step
    typedef enum logic [1:0] {
        C_ACCEPT = 2'd0,
        C_SKIP   = 2'd1,
        C_NEVER  = 2'd2,
        C_DONE   = 2'd3
    } cond_t;

    // One control word: taken -> target, else hold or fall through
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } ucode_word_t;

    typedef struct packed {
        op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic accepted;
        logic skip;
        logic done;
    } dp_stat_t;

endpackage

>>> hdl/zrv_if.sv
// Handshake channel interfaces for the zero-run visibility decoder.
// Input byte channel and output bitmap word channel; no dependencies.
interface zrv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] code_byte;

    modport source (output valid, output action, output code_byte, input ready);
    modport sink   (input valid, input action, input code_byte, output ready);
endinterface

interface zrv_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] bitmap_word;
    logic [3:0]  valid_bytes;
    logic        row_last;

    modport source (output valid, output bitmap_word, output valid_bytes, output row_last,
                    input ready);
    modport sink   (input valid, input bitmap_word, input valid_bytes, input row_last,
                    output ready);
endinterface

>>> hdl/zero_run_visibility_decoder_unit.sv
// Zero-run visibility decoder. Takes one coded byte per transfer on code_in and
// returns the expanded visibility row on bitmap_out, eight bytes to a word,
// first byte in bits 7:0, the last word of the row flagged with row_last.
// A small microprogram (load, start, set run, push) runs each byte. A byte
// is dropped at the start step on action 3, a continue with no row open, or
// a new or all-visible row of zero length. Otherwise the push step emits the
// run in chunks, each filling the packer up to the next word boundary, the
// run end or the row end. Output back-pressure stalls the push step.
// Writing leaf_count (APB offset 0) also drops any row in progress.
// Depends on zrv_pkg, zrv_if, zrv_apb, zrv_useq and zrv_dpath.
module zero_run_visibility_decoder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [zrv_pkg::ADDR_W-1:0]   paddr,
    input  logic [zrv_pkg::DATA_W-1:0]   pwdata,
    output logic [zrv_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    zrv_in_if.sink                       code_in,
    zrv_out_if.source                    bitmap_out
);

    logic [zrv_pkg::ROW_W-1:0] row_len;
    logic                      cfg_clear;
    zrv_pkg::dp_ctrl_t         ctrl;
    zrv_pkg::dp_stat_t         stat;

    // Configuration registers
    zrv_apb u_apb (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .row_len   (row_len),
        .cfg_clear (cfg_clear)
    );

    // Microcode sequencer
    zrv_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_clear),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Datapath
    zrv_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_in    (code_in),
        .bitmap_out (bitmap_out),
        .ctrl       (ctrl),
        .stat       (stat),
        .row_len    (row_len),
        .cfg_clear  (cfg_clear)
    );

endmodule

>>> hdl/zrv_apb.sv
// APB register port: holds leaf_count and derives the row length in bytes.
// Depends on zrv_pkg.
module zrv_apb (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [zrv_pkg::ADDR_W-1:0]   paddr,
    input  logic [zrv_pkg::DATA_W-1:0]   pwdata,
    output logic [zrv_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [zrv_pkg::ROW_W-1:0]    row_len,
    output logic                         cfg_clear
);

    logic [zrv_pkg::LEAF_W-1:0] leaf_reg;
    logic [zrv_pkg::LEAF_W-1:0] leaf_next;
    logic [zrv_pkg::LEAF_W-1:0] leaf_clip;
    logic [zrv_pkg::LEAF_W:0]   leaf_sum;
    logic                       hit;

    assign pready    = 1'b1;
    assign hit       = (paddr[zrv_pkg::REG_IDX_LSB] == zrv_pkg::REG_LEAF_COUNT);
    assign cfg_clear = psel && penable && pwrite && hit;

    // Register write
    always_comb
    begin
        leaf_next = leaf_reg;
        if (cfg_clear)
        begin
            leaf_next = pwdata[zrv_pkg::LEAF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_reg <= '0;
        end
        else
        begin
            leaf_reg <= leaf_next;
        end
    end

    // Readback
    assign prdata = hit ? zrv_pkg::DATA_W'(leaf_reg) : '0;

    // Row length = (min(leaves, max) + 7) / 8
    assign leaf_clip = (leaf_reg > zrv_pkg::LEAF_W'(zrv_pkg::MAX_LEAVES))
                     ? zrv_pkg::LEAF_W'(zrv_pkg::MAX_LEAVES) : leaf_reg;
    assign leaf_sum  = {1'b0, leaf_clip} + zrv_pkg::ROUND_UP;
    assign row_len   = zrv_pkg::ROW_W'(leaf_sum >> 3);

endmodule

>>> hdl/zrv_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on zrv_pkg.
module zrv_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_clear,
    input  zrv_pkg::dp_stat_t   stat,
    output zrv_pkg::dp_ctrl_t   ctrl
);

    // Control program
    localparam zrv_pkg::ucode_word_t UCODE [zrv_pkg::UC_DEPTH] = '{
        // wait for a byte
        '{op: zrv_pkg::OP_LOAD,   cond: zrv_pkg::C_ACCEPT, hold: 1'b1,
          target: zrv_pkg::STEP_START},
        // open a new row if asked; drop the byte if nothing to do
        '{op: zrv_pkg::OP_START,  cond: zrv_pkg::C_SKIP,   hold: 1'b0,
          target: zrv_pkg::STEP_LOAD},
        // work out the run to emit
        '{op: zrv_pkg::OP_SETRUN, cond: zrv_pkg::C_NEVER,  hold: 1'b0,
          target: zrv_pkg::STEP_LOAD},
        // emit chunks until the run or the row ends
        '{op: zrv_pkg::OP_PUSH,   cond: zrv_pkg::C_DONE,   hold: 1'b1,
          target: zrv_pkg::STEP_LOAD}
    };

    zrv_pkg::step_t       pc_reg;
    zrv_pkg::step_t       pc_next;
    zrv_pkg::ucode_word_t uword;
    logic                 taken;

    assign uword   = UCODE[pc_reg];
    assign ctrl.op = uword.op;

    // Condition select
    always_comb
    begin
        unique case (uword.cond)
            zrv_pkg::C_ACCEPT: taken = stat.accepted;
            zrv_pkg::C_SKIP:   taken = stat.skip;
            zrv_pkg::C_NEVER:  taken = 1'b0;
            zrv_pkg::C_DONE:   taken = stat.done;
            default:           taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        priority if (cfg_clear)
        begin
            pc_next = zrv_pkg::STEP_LOAD;
        end
        else if (taken)
        begin
            pc_next = uword.target;
        end
        else if (uword.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + zrv_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= zrv_pkg::STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hdl/zrv_dpath.sv
// Decoder datapath: input latch, row state, run counter, byte packer
// and output register. Driven by the microcode sequencer; depends on zrv_pkg.
module zrv_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    zrv_in_if.sink                      code_in,
    zrv_out_if.source                   bitmap_out,
    input  zrv_pkg::dp_ctrl_t           ctrl,
    output zrv_pkg::dp_stat_t           stat,
    input  logic [zrv_pkg::ROW_W-1:0]   row_len,
    input  logic                        cfg_clear
);

    localparam int RW = zrv_pkg::ROW_W;

    logic [1:0]    action_reg, action_next;
    logic [7:0]    code_reg,   code_next;
    logic [7:0]    value_reg,  value_next;
    logic [RW-1:0] run_reg,    run_next;
    logic [RW-1:0] emitted_reg, emitted_next;
    logic          expect_reg, expect_next;
    logic          open_reg,   open_next;
    logic [55:0]   pack_reg,   pack_next;
    logic [2:0]    fill_reg,   fill_next;

    logic          ovalid_reg, ovalid_next;
    logic [63:0]   oword_reg,  oword_next;
    logic [3:0]    obytes_reg, obytes_next;
    logic          olast_reg,  olast_next;

    logic          accepted;
    logic          out_free;
    logic          starts;
    logic          row_nz;
    logic          open_eff;
    logic [RW-1:0] rem;
    logic [RW-1:0] run_min;
    logic [3:0]    space;
    logic [3:0]    n;
    logic [3:0]    end_lane;
    logic [63:0]   word_mix;
    logic          last;
    logic          emit;
    logic          work;
    logic          fire;

    // Handshakes
    assign code_in.ready = (ctrl.op == zrv_pkg::OP_LOAD);
    assign accepted      = code_in.valid && code_in.ready;
    assign out_free      = !ovalid_reg || bitmap_out.ready;

    // Row start decode
    assign starts   = (action_reg == zrv_pkg::ACT_NEW) || (action_reg == zrv_pkg::ACT_FILL);
    assign row_nz   = (row_len != '0);
    assign open_eff = starts ? row_nz : open_reg;

    // Chunk size: min(run, room in word, bytes left in row)
    assign rem      = row_len - emitted_reg;
    assign run_min  = (run_reg < rem) ? run_reg : rem;
    assign space    = 4'd8 - {1'b0, fill_reg};
    assign n        = (run_min < RW'(space)) ? run_min[3:0] : space;
    assign end_lane = {1'b0, fill_reg} + n;

    // Merge chunk bytes into the packed word
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if ((4'(i) >= {1'b0, fill_reg}) && (4'(i) < end_lane))
            begin
                word_mix[8*i +: 8] = value_reg;
            end
            else if (i < 7)
            begin
                word_mix[8*i +: 8] = pack_reg[8*(i%7) +: 8];
            end
            else
            begin
                word_mix[8*i +: 8] = 8'h00;
            end
        end
    end

    assign last = (RW'(n) == rem);
    assign emit = end_lane[3] || last;
    assign work = open_reg && (run_reg != '0);
    assign fire = (ctrl.op == zrv_pkg::OP_PUSH) && work && out_free;

    // Status to the sequencer
    assign stat.accepted = accepted;
    assign stat.skip     = (action_reg == zrv_pkg::ACT_NONE) || !open_eff;
    assign stat.done     = !work || (fire && ((RW'(n) == run_reg) || last));

    // Next state
    always_comb
    begin
        action_next  = action_reg;
        code_next    = code_reg;
        value_next   = value_reg;
        run_next     = run_reg;
        emitted_next = emitted_reg;
        expect_next  = expect_reg;
        open_next    = open_reg;
        pack_next    = pack_reg;
        fill_next    = fill_reg;

        priority if (cfg_clear)
        begin
            emitted_next = '0;
            expect_next  = 1'b0;
            open_next    = 1'b0;
            pack_next    = '0;
            fill_next    = '0;
        end
        else
        begin
            unique case (ctrl.op)
                zrv_pkg::OP_LOAD:
                begin
                    if (accepted)
                    begin
                        action_next = code_in.action;
                        code_next   = code_in.code_byte;
                    end
                end
                zrv_pkg::OP_START:
                begin
                    if (starts)
                    begin
                        emitted_next = '0;
                        expect_next  = 1'b0;
                        pack_next    = '0;
                        fill_next    = '0;
                        open_next    = row_nz;
                    end
                end
                zrv_pkg::OP_SETRUN:
                begin
                    priority if (action_reg == zrv_pkg::ACT_FILL)
                    begin
                        run_next   = row_len;
                        value_next = zrv_pkg::FILL_BYTE;
                    end
                    else if (expect_reg)
                    begin
                        // this byte is a zero-run count
                        run_next    = RW'(code_reg);
                        value_next  = 8'h00;
                        expect_next = 1'b0;
                    end
                    else if (code_reg != 8'h00)
                    begin
                        run_next   = RW'(1);
                        value_next = code_reg;
                    end
                    else
                    begin
                        run_next    = '0;
                        expect_next = 1'b1;
                    end
                end
                zrv_pkg::OP_PUSH:
                begin
                    if (fire)
                    begin
                        emitted_next = emitted_reg + RW'(n);
                        run_next     = run_reg - RW'(n);
                        if (emit)
                        begin
                            pack_next = '0;
                            fill_next = '0;
                            if (last)
                            begin
                                open_next = 1'b0;
                            end
                        end
                        else
                        begin
                            pack_next = word_mix[55:0];
                            fill_next = end_lane[2:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;
        obytes_next = obytes_reg;
        olast_next  = olast_reg;
        priority if (fire && emit)
        begin
            ovalid_next = 1'b1;
            oword_next  = word_mix;
            obytes_next = end_lane;
            olast_next  = last;
        end
        else if (bitmap_out.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitted_reg <= '0;
            expect_reg  <= 1'b0;
            open_reg    <= 1'b0;
            pack_reg    <= '0;
            fill_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            emitted_reg <= emitted_next;
            expect_reg  <= expect_next;
            open_reg    <= open_next;
            pack_reg    <= pack_next;
            fill_reg    <= fill_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        code_reg   <= code_next;
        value_reg  <= value_next;
        run_reg    <= run_next;
        oword_reg  <= oword_next;
        obytes_reg <= obytes_next;
        olast_reg  <= olast_next;
    end

    assign bitmap_out.valid       = ovalid_reg;
    assign bitmap_out.bitmap_word = oword_reg;
    assign bitmap_out.valid_bytes = obytes_reg;
    assign bitmap_out.row_last    = olast_reg;

endmodule
